>>> rtl/core/qcs_pkg.sv
// Shared constants and types for the quoted command splitter.
// No dependencies.
package qcs_pkg;

  localparam int CODE_UNIT_BITS_DEF = 16;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Command for the back end: up to two characters, then an optional token end.
  typedef struct packed {
    logic [1:0] n_chars;
    logic       done;
  } cmd_t;

endpackage

>>> rtl/core/qcs_front.sv
// Front end: accepts input words, tracks quote/backslash/token state and
// classifies each word into a command for the queue. Uses qcs_pkg.
module qcs_front import qcs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CODE_UNIT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CODE_UNIT_BITS-1:0] code_unit,
  input  logic                      unit_present,
  input  logic                      string_end,
  input  logic                      q_full,
  output logic                      push,
  output cmd_t                      push_cmd,
  output logic [CODE_UNIT_BITS-1:0] push_c0,
  output logic [CODE_UNIT_BITS-1:0] push_c1
);

  localparam logic [CODE_UNIT_BITS-1:0] SP = CODE_UNIT_BITS'(CH_SPACE);
  localparam logic [CODE_UNIT_BITS-1:0] QU = CODE_UNIT_BITS'(CH_QUOTE);
  localparam logic [CODE_UNIT_BITS-1:0] BS = CODE_UNIT_BITS'(CH_BSLASH);

  logic in_quotes, held_backslash, token_open;
  logic in_quotes_next, held_backslash_next, token_open_next;
  logic is_sp, is_qu, is_bs, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_sp    = (code_unit == SP);
  assign is_qu    = (code_unit == QU);
  assign is_bs    = (code_unit == BS);

  always_comb begin
    in_quotes_next      = in_quotes;
    held_backslash_next = held_backslash;
    token_open_next     = token_open;
    push_cmd            = '0;
    push_c0             = '0;
    push_c1             = '0;
    if (unit_present) begin
      if (held_backslash) begin
        held_backslash_next = 1'b0;
        if (is_qu || is_bs) begin
          push_cmd.n_chars = 2'd1;
          push_c0          = code_unit;
        end else begin
          push_cmd.n_chars = 2'd2;
          push_c0          = BS;
          push_c1          = code_unit;
        end
        token_open_next = 1'b1;
      end else if (!in_quotes) begin
        if (is_sp || is_qu) begin
          if (token_open) begin
            push_cmd.done   = 1'b1;
            token_open_next = 1'b0;
          end
          if (is_qu) in_quotes_next = 1'b1;
        end else begin
          push_cmd.n_chars = 2'd1;
          push_c0          = code_unit;
          token_open_next  = 1'b1;
        end
      end else begin
        if (is_bs) begin
          held_backslash_next = 1'b1;
        end else if (is_qu) begin
          in_quotes_next  = 1'b0;
          push_cmd.done   = 1'b1;
          token_open_next = 1'b0;
        end else begin
          push_cmd.n_chars = 2'd1;
          push_c0          = code_unit;
          token_open_next  = 1'b1;
        end
      end
    end
    if (string_end) begin
      // A held backslash can only coexist with no characters so far.
      if (held_backslash_next) begin
        push_cmd.n_chars = 2'd1;
        push_c0          = BS;
        token_open_next  = 1'b1;
      end
      if (token_open_next) push_cmd.done = 1'b1;
      in_quotes_next      = 1'b0;
      held_backslash_next = 1'b0;
      token_open_next     = 1'b0;
    end
  end

  assign push = accept && ((push_cmd.n_chars != 2'd0) || push_cmd.done);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      held_backslash <= 1'b0;
      token_open     <= 1'b0;
    end else if (accept) begin
      in_quotes      <= in_quotes_next;
      held_backslash <= held_backslash_next;
      token_open     <= token_open_next;
    end
  end

endmodule

>>> rtl/core/qcs_queue.sv
// Short command queue between the front and back ends.
// Uses qcs_pkg for depth and the command type.
module qcs_queue import qcs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CODE_UNIT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  cmd_t                      push_cmd,
  input  logic [CODE_UNIT_BITS-1:0] push_c0,
  input  logic [CODE_UNIT_BITS-1:0] push_c1,
  output logic                      full,
  output logic                      head_valid,
  output cmd_t                      head_cmd,
  output logic [CODE_UNIT_BITS-1:0] head_c0,
  output logic [CODE_UNIT_BITS-1:0] head_c1,
  input  logic                      pop
);

  cmd_t                      cmds [QUEUE_DEPTH];
  logic [CODE_UNIT_BITS-1:0] c0s  [QUEUE_DEPTH];
  logic [CODE_UNIT_BITS-1:0] c1s  [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full       = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = cmds[rd_ptr];
  assign head_c0    = c0s[rd_ptr];
  assign head_c1    = c1s[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      cmds[wr_ptr] <= push_cmd;
      c0s[wr_ptr]  <= push_c0;
      c1s[wr_ptr]  <= push_c1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/qcs_back.sv
// Back end: unrolls each queued command into result words, one a cycle while
// out_stall is low, through a registered output stage. Uses qcs_pkg.
module qcs_back import qcs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CODE_UNIT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  cmd_t                      head_cmd,
  input  logic [CODE_UNIT_BITS-1:0] head_c0,
  input  logic [CODE_UNIT_BITS-1:0] head_c1,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CODE_UNIT_BITS-1:0] token_char,
  output logic                      char_valid,
  output logic                      token_done,
  output logic                      run_last
);

  logic [1:0] step;
  logic [1:0] total;
  logic       load, is_char, last;

  assign total   = head_cmd.n_chars + {1'b0, head_cmd.done};
  assign is_char = (step < head_cmd.n_chars);
  assign last    = (step == total - 2'd1);
  assign load    = head_valid && (!out_valid || !out_stall);
  assign pop     = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= last ? 2'd0 : step + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_char <= is_char ? ((step == 2'd0) ? head_c0 : head_c1) : '0;
      char_valid <= is_char;
      token_done <= !is_char;
      run_last   <= last;
    end
  end

endmodule

>>> rtl/core/quoted_command_splitter.sv
// Top level of the quoted command splitter: front end, command queue, back end.
// Uses qcs_pkg, qcs_front, qcs_queue and qcs_back.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   code_unit, unit_present, string_end
// out      output     out_valid / out_stall token_char, char_valid, token_done, run_last
//
// The front end takes one input word per cycle unless in_stall; the back end gives one
// result word per cycle unless out_stall, so an input word causing n results occupies
// the back end until all n are given. A four-entry queue separates the two; in_stall
// rises only when it is full. Each command passes the queue, then the output register.
// rst is synchronous and clears all control state; the first word may follow at once.
module quoted_command_splitter import qcs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CODE_UNIT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CODE_UNIT_BITS-1:0] code_unit,
  input  logic                      unit_present,
  input  logic                      string_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CODE_UNIT_BITS-1:0] token_char,
  output logic                      char_valid,
  output logic                      token_done,
  output logic                      run_last
);

  logic                      q_full, push, pop, head_valid;
  cmd_t                      push_cmd, head_cmd;
  logic [CODE_UNIT_BITS-1:0] push_c0, push_c1, head_c0, head_c1;

  qcs_front #(.CODE_UNIT_BITS(CODE_UNIT_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .code_unit    (code_unit),
    .unit_present (unit_present),
    .string_end   (string_end),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_c0      (push_c0),
    .push_c1      (push_c1)
  );

  qcs_queue #(.CODE_UNIT_BITS(CODE_UNIT_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_c0    (push_c0),
    .push_c1    (push_c1),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_c0    (head_c0),
    .head_c1    (head_c1),
    .pop        (pop)
  );

  qcs_back #(.CODE_UNIT_BITS(CODE_UNIT_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_c0    (head_c0),
    .head_c1    (head_c1),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_char (token_char),
    .char_valid (char_valid),
    .token_done (token_done),
    .run_last   (run_last)
  );

endmodule

>>> tb/quoted_command_splitter_test.sv
// Self-checking testbench for quoted_command_splitter: directed and random
// command strings go in, and a built-in tokenizer predicts every result word.
// Depends on qcs_pkg and the quoted_command_splitter RTL.
module quoted_command_splitter_test;
  import qcs_pkg::*;

  localparam logic [15:0] U_SPACE  = 16'(CH_SPACE);
  localparam logic [15:0] U_QUOTE  = 16'(CH_QUOTE);
  localparam logic [15:0] U_BSLASH = 16'(CH_BSLASH);
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [15:0] ch;
    logic        ch_ok;
    logic        done;
    logic        last;
  } arg_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] code_unit = '0;
  logic        unit_present = 1'b0;
  logic        string_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] token_char;
  logic        char_valid;
  logic        token_done;
  logic        run_last;

  // tokenizer state
  logic quoted = 1'b0;
  logic escape_held = 1'b0;
  logic arg_open = 1'b0;

  arg_word_t arg_words[$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        quiet_cycles = 0;
  logic      no_gaps = 1'b0;

  quoted_command_splitter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .code_unit(code_unit), .unit_present(unit_present), .string_end(string_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .token_char(token_char), .char_valid(char_valid),
    .token_done(token_done), .run_last(run_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic push_char(input logic [15:0] ch);
    arg_word_t w;
    w = '{ch: ch, ch_ok: 1'b1, done: 1'b0, last: 1'b0};
    arg_words = {arg_words, w};
  endtask

  task automatic push_end();
    arg_word_t w;
    w = '{ch: 16'h0000, ch_ok: 1'b0, done: 1'b1, last: 1'b0};
    arg_words = {arg_words, w};
  endtask

  // Works out the result words of one accepted word and queues them.
  task automatic split_unit(input logic [15:0] unit, input logic present, input logic last);
    int base;
    base = arg_words.size();
    if (present) begin
      if (escape_held) begin
        escape_held = 1'b0;
        if (unit != U_QUOTE && unit != U_BSLASH) push_char(U_BSLASH);
        push_char(unit);
        arg_open = 1'b1;
      end else if (!quoted) begin
        if (unit == U_SPACE || unit == U_QUOTE) begin
          if (arg_open) push_end();
          arg_open = 1'b0;
          if (unit == U_QUOTE) quoted = 1'b1;
        end else begin
          push_char(unit);
          arg_open = 1'b1;
        end
      end else if (unit == U_BSLASH) begin
        escape_held = 1'b1;
      end else if (unit == U_QUOTE) begin
        quoted = 1'b0;
        push_end();
        arg_open = 1'b0;
      end else begin
        push_char(unit);
        arg_open = 1'b1;
      end
    end
    if (last) begin
      if (escape_held) begin
        push_char(U_BSLASH);
        arg_open = 1'b1;
      end
      if (arg_open) push_end();
      quoted = 1'b0;
      escape_held = 1'b0;
      arg_open = 1'b0;
    end
    if (arg_words.size() > base) arg_words[arg_words.size() - 1].last = 1'b1;
  endtask

  task automatic send_word(input logic [15:0] unit, input logic present, input logic last);
    int gap;
    if (!no_gaps && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, 2);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    code_unit = unit;
    unit_present = present;
    string_end = last;
    do @(posedge clk); while (in_stall);
    split_unit(unit, present, last);
    if (present || last) words_sent++;
  endtask

  function automatic logic [15:0] pick_unit();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return U_SPACE;
    if (roll < 45) return U_QUOTE;
    if (roll < 65) return U_BSLASH;
    if (roll < 88) return 16'h0061 + 16'($urandom_range(25));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // One well-formed command string with random content.
  task automatic send_command(input int len);
    for (int i = 0; i < len; i++) send_word(pick_unit(), 1'b1, 1'b0);
    if ($urandom_range(1)) send_word(pick_unit(), 1'b1, 1'b1);
    else send_word(16'($urandom_range(16'hFFFF)), 1'b0, 1'b1);
  endtask

  task automatic test_special_cases();
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(U_SPACE, 1'b1, 1'b0);
    send_word(U_SPACE, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);    // empty word, nothing out
    send_word(U_QUOTE, 1'b1, 1'b0);
    send_word(U_QUOTE, 1'b1, 1'b0);     // empty quoted argument
    send_word(U_BSLASH, 1'b1, 1'b0);    // plain backslash outside quotes
    send_word(U_QUOTE, 1'b1, 1'b0);
    send_word(U_BSLASH, 1'b1, 1'b0);
    send_word(U_QUOTE, 1'b1, 1'b0);     // escaped quote
    send_word(U_BSLASH, 1'b1, 1'b0);
    send_word(U_BSLASH, 1'b1, 1'b0);    // escaped backslash
    send_word(U_BSLASH, 1'b1, 1'b0);
    send_word(16'h0078, 1'b1, 1'b0);    // backslash kept before ordinary unit
    send_word(U_BSLASH, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b1);    // end with backslash held
    send_word(U_QUOTE, 1'b1, 1'b0);
    send_word(16'h0071, 1'b1, 1'b1);    // open quote at end, argument flushed
    send_word(U_QUOTE, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b1);    // open quote at end, nothing out
    send_word(U_QUOTE, 1'b1, 1'b0);
    send_word(U_BSLASH, 1'b1, 1'b0);
    send_word(16'h007A, 1'b1, 1'b1);    // three words from one
    send_word(U_SPACE, 1'b1, 1'b1);
    send_word(16'hFFFF, 1'b0, 1'b0);
  endtask

  task automatic test_command_lines();
    while (words_sent < 260) send_command($urandom_range(0, 10));
  endtask

  task automatic test_unbroken_stream();
    no_gaps = 1'b1;
    while (words_sent < 320) send_command($urandom_range(0, 12));
    no_gaps = 1'b0;
  endtask

  task automatic test_noise();
    logic [15:0] unit;
    while (words_sent < 360) begin
      unit = $urandom_range(1) ? 16'($urandom_range(16'hFFFF)) : pick_unit();
      send_word(unit, $urandom_range(99) < 80, $urandom_range(99) < 15);
    end
  endtask

  task automatic report(input string what, input arg_word_t want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%s: want char %h/%b done %b last %b, got char %h/%b done %b last %b",
               what, want.ch, want.ch_ok, want.done, want.last,
               token_char, char_valid, token_done, run_last);
  endtask

  always @(posedge clk) begin : check_results
    arg_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (arg_words.size() == 0) begin
        report("unexpected word", '0);
      end else begin
        want = arg_words.pop_front();
        if (token_char !== want.ch || char_valid !== want.ch_ok ||
            token_done !== want.done || run_last !== want.last)
          report("mismatch", want);
      end
    end
  end

  always @(negedge clk)
    out_stall = !no_gaps && ($urandom_range(99) < 15);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_special_cases();
    test_command_lines();
    test_unbroken_stream();
    test_noise();
    @(negedge clk);
    in_valid = 1'b0;
    while (arg_words.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && arg_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/qcs_pkg.sv
rtl/core/qcs_front.sv
rtl/core/qcs_queue.sv
rtl/core/qcs_back.sv
rtl/core/quoted_command_splitter.sv
tb/quoted_command_splitter_test.sv
